// ===== src/rwv_pkg.sv =====
package rwv_pkg;

    // Fixed field widths of the stream payloads.
    localparam int INSTR_W   = 16;
    localparam int VALUE_W   = 32;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;
    localparam int RESULT_W  = 50;

    // Actions carried in s_tuser.
    localparam logic ACT_EXEC  = 1'b0;
    localparam logic ACT_CONST = 1'b1;

    // Opcodes, instruction bits 15..12. Other codes do nothing.
    localparam logic [3:0] OP_HALT = 4'd0;
    localparam logic [3:0] OP_MOVI = 4'd1;
    localparam logic [3:0] OP_ADD  = 4'd2;
    localparam logic [3:0] OP_CALL = 4'd3;
    localparam logic [3:0] OP_RET  = 4'd4;
    localparam logic [3:0] OP_MOV  = 4'd5;
    localparam logic [3:0] OP_LDC  = 4'd6;

    // Result item; the first member sits in the highest bits, so halted lands at bit 0.
    typedef struct packed {
        logic               fault;
        logic [VALUE_W-1:0] write_value;
        logic [4:0]         write_slot;
        logic               wrote;
        logic [7:0]         next_pc;
        logic [1:0]         next_function;
        logic               halted;
    } result_t;

endpackage

// ===== src/rwv_ram.sv =====
module rwv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read and a write to the same address return the old word.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rwv_exec.sv =====
module rwv_exec #(
    parameter int REG_DEPTH       = 32,
    parameter int NUM_FUNCS       = 4,
    parameter int CONSTS_PER_FUNC = 16,
    parameter int PROG_DEPTH      = 256
) (
    input  logic                                   action,
    input  logic [rwv_pkg::INSTR_W-1:0]            instr,
    input  logic [1:0]                             const_function,
    input  logic [3:0]                             const_slot,
    input  logic                                   halt,
    input  logic [$clog2(NUM_FUNCS)-1:0]           cur_fn,
    input  logic [$clog2(PROG_DEPTH)-1:0]          pc,
    input  logic [$clog2(REG_DEPTH)-1:0]           base,
    input  logic [$clog2(NUM_FUNCS)-1:0]           saved_fn,
    input  logic [$clog2(PROG_DEPTH)-1:0]          saved_pc,
    input  logic [$clog2(REG_DEPTH)-1:0]           saved_base,
    input  logic [rwv_pkg::VALUE_W-1:0]            rd_p,
    input  logic [rwv_pkg::VALUE_W-1:0]            rd_q,
    input  logic [rwv_pkg::VALUE_W-1:0]            rd_const,
    output logic                                   halt_next,
    output logic [$clog2(NUM_FUNCS)-1:0]           fn_next,
    output logic [$clog2(PROG_DEPTH)-1:0]          pc_next,
    output logic [$clog2(REG_DEPTH)-1:0]           base_next,
    output logic [$clog2(NUM_FUNCS)-1:0]           saved_fn_next,
    output logic [$clog2(PROG_DEPTH)-1:0]          saved_pc_next,
    output logic [$clog2(REG_DEPTH)-1:0]           saved_base_next,
    output logic                                   reg_we,
    output logic [$clog2(REG_DEPTH)-1:0]           reg_waddr,
    output logic [rwv_pkg::VALUE_W-1:0]            reg_wdata,
    output logic                                   const_we,
    output logic [$clog2(NUM_FUNCS*CONSTS_PER_FUNC)-1:0] const_waddr,
    output rwv_pkg::result_t                       result
);

    import rwv_pkg::*;

    localparam int FW  = $clog2(NUM_FUNCS);
    localparam int PW  = $clog2(PROG_DEPTH);
    localparam int BW  = $clog2(REG_DEPTH);
    localparam int CAW = $clog2(NUM_FUNCS * CONSTS_PER_FUNC);
    localparam int SW  = BW + 5;

    logic [3:0]         op;
    logic [3:0]         fa, fb, fc;
    logic [7:0]         imm;
    logic [SW-1:0]      sa, sb, sc;
    logic               sa_bad, sb_bad, sc_bad, imm_bad, fn_bad;
    logic               cw_bad;
    logic [PW-1:0]      pc_inc;
    logic               wr;
    logic               flt;
    logic [VALUE_W-1:0] val;
    logic [31:0]        caddr_w;
    logic [31:0]        fn_w;
    logic [31:0]        pc_w;

    assign op  = instr[15:12];
    assign fa  = instr[11:8];
    assign fb  = instr[7:4];
    assign fc  = instr[3:0];
    assign imm = instr[7:0];

    assign sa = SW'(base) + SW'(fa);
    assign sb = SW'(base) + SW'(fb);
    assign sc = SW'(base) + SW'(fc);

    assign sa_bad  = sa >= SW'(REG_DEPTH);
    assign sb_bad  = sb >= SW'(REG_DEPTH);
    assign sc_bad  = sc >= SW'(REG_DEPTH);
    assign imm_bad = 32'(imm) >= 32'(CONSTS_PER_FUNC);
    assign fn_bad  = rd_p >= 32'(NUM_FUNCS);
    assign cw_bad  = (32'(const_function) >= 32'(NUM_FUNCS))
                  || (32'(const_slot) >= 32'(CONSTS_PER_FUNC));

    assign pc_inc = (pc == PW'(PROG_DEPTH - 1)) ? '0 : pc + PW'(1);

    assign caddr_w = 32'(const_function) * 32'(CONSTS_PER_FUNC) + 32'(const_slot);

    always_comb begin
        halt_next       = halt;
        fn_next         = cur_fn;
        pc_next         = pc;
        base_next       = base;
        saved_fn_next   = saved_fn;
        saved_pc_next   = saved_pc;
        saved_base_next = saved_base;
        wr              = 1'b0;
        flt             = 1'b0;
        val             = '0;
        const_we        = 1'b0;
        if (action == ACT_CONST) begin
            if (cw_bad) begin
                flt = 1'b1;
            end else begin
                const_we = 1'b1;
            end
        end else if (!halt) begin
            unique case (op)
                OP_HALT: begin
                    halt_next = 1'b1;
                    pc_next   = pc_inc;
                end
                OP_MOVI, OP_ADD, OP_MOV, OP_LDC: begin
                    if (sa_bad
                        || ((op == OP_ADD || op == OP_MOV) && sb_bad)
                        || (op == OP_ADD && sc_bad)
                        || (op == OP_LDC && imm_bad)) begin
                        flt = 1'b1;
                    end else begin
                        wr      = 1'b1;
                        pc_next = pc_inc;
                        if (op == OP_MOVI) begin
                            val = VALUE_W'(imm);
                        end else if (op == OP_ADD) begin
                            val = rd_p + rd_q;
                        end else if (op == OP_MOV) begin
                            val = rd_p;
                        end else begin
                            val = rd_const;
                        end
                    end
                end
                OP_CALL: begin
                    if (sa_bad || sb_bad || fn_bad) begin
                        flt = 1'b1;
                    end else begin
                        saved_pc_next   = pc_inc;
                        saved_base_next = base;
                        saved_fn_next   = cur_fn;
                        fn_next         = rd_p[FW-1:0];
                        pc_next         = '0;
                        base_next       = sb[BW-1:0];
                    end
                end
                OP_RET: begin
                    fn_next   = saved_fn;
                    pc_next   = saved_pc;
                    base_next = saved_base;
                end
                default: begin
                    pc_next = pc_inc;
                end
            endcase
        end
    end

    assign reg_we      = wr;
    assign reg_waddr   = sa[BW-1:0];
    assign reg_wdata   = val;
    assign const_waddr = caddr_w[CAW-1:0];

    assign fn_w = 32'(fn_next);
    assign pc_w = 32'(pc_next);

    always_comb begin
        result.halted        = halt_next;
        result.next_function = fn_w[1:0];
        result.next_pc       = pc_w[7:0];
        result.wrote         = wr;
        result.write_slot    = wr ? sa[4:0] : 5'd0;
        result.write_value   = val;
        result.fault         = flt;
    end

endmodule

// ===== src/register_window_vm_execute_top.sv =====
// Channel | Ports                       | Carries
// input   | s_tvalid s_tready s_tdata   | one instruction or one constant-entry write
//         | s_tuser                     | action
// result  | m_tvalid m_tready m_tdata   | next fetch location, register write, flags
//
// One transaction per clock in steady state while results are not stalled on m_tready.
// The input stage reads the register and constant stores (registered reads), the execute
// stage decodes, adds and updates the state and stores, and the output register holds
// the result. A result that waits on m_tready stalls the execute stage, which then
// holds s_tready low. Reset is synchronous (aresetn low) and clears the machine state
// and the register-store valid bits; constant entries are undefined until written.
module register_window_vm_execute_top #(
    parameter int REG_DEPTH       = 32,
    parameter int NUM_FUNCS       = 4,
    parameter int CONSTS_PER_FUNC = 16,
    parameter int PROG_DEPTH      = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // instruction[15:0], const_function[17:16], const_slot[21:18],
    // const_value[53:22], zero padding[55:54]
    input  logic [rwv_pkg::S_TDATA_W-1:0]    s_tdata,
    // action[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // halted[0], next_function[2:1], next_pc[10:3], wrote[11], write_slot[16:12],
    // write_value[48:17], fault[49], zero padding[55:50]
    output logic [rwv_pkg::M_TDATA_W-1:0]    m_tdata
);

    import rwv_pkg::*;

    localparam int FW  = $clog2(NUM_FUNCS);
    localparam int PW  = $clog2(PROG_DEPTH);
    localparam int BW  = $clog2(REG_DEPTH);
    localparam int CAW = $clog2(NUM_FUNCS * CONSTS_PER_FUNC);
    localparam int SW  = BW + 5;
    localparam int CDEPTH = NUM_FUNCS * CONSTS_PER_FUNC;

    // Execute stage.
    logic                 e_valid_reg;
    logic                 e_act_reg;
    logic [INSTR_W-1:0]   e_ins_reg;
    logic [1:0]           e_cfn_reg;
    logic [3:0]           e_slot_reg;
    logic [VALUE_W-1:0]   e_cval_reg;

    // Machine state.
    logic                 halt_reg;
    logic [FW-1:0]        fn_reg;
    logic [PW-1:0]        pc_reg;
    logic [BW-1:0]        base_reg;
    logic [FW-1:0]        sfn_reg;
    logic [PW-1:0]        spc_reg;
    logic [BW-1:0]        sbase_reg;
    logic [REG_DEPTH-1:0] vld_reg;

    // Read bypass for a write that lands on the edge of the read.
    logic                 qa_hit_reg, qb_hit_reg, k_hit_reg;
    logic                 qa_vld_reg, qb_vld_reg;
    logic [VALUE_W-1:0]   qa_val_reg, qb_val_reg, k_val_reg;

    logic                 m_valid_reg;
    result_t              m_res_reg;

    logic                 in_fire;
    logic                 e_fire;

    logic                 halt_nx;
    logic [FW-1:0]        fn_nx;
    logic [PW-1:0]        pc_nx;
    logic [BW-1:0]        base_nx;
    logic [FW-1:0]        sfn_nx;
    logic [PW-1:0]        spc_nx;
    logic [BW-1:0]        sbase_nx;
    logic                 reg_we;
    logic [BW-1:0]        reg_waddr;
    logic [VALUE_W-1:0]   reg_wdata;
    logic                 const_we;
    logic [CAW-1:0]       const_waddr;
    result_t              res;

    logic [3:0]           in_op;
    logic [BW-1:0]        base_sel;
    logic [FW-1:0]        fn_sel;
    logic [SW-1:0]        ra_sum, rb_sum;
    logic [BW-1:0]        ra_addr, rb_addr;
    logic                 ra_ok, rb_ok;
    logic [31:0]          k_sum;
    logic [CAW-1:0]       k_addr;
    logic                 do_reg_we, do_const_we;

    logic [VALUE_W-1:0]   ram_a_q, ram_b_q, ram_k_q;
    logic [VALUE_W-1:0]   rd_p, rd_q, rd_k;

    assign e_fire   = e_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !e_valid_reg || e_fire;
    assign in_fire  = s_tvalid && s_tready;

    assign do_reg_we   = e_fire && reg_we;
    assign do_const_we = e_fire && const_we;

    // Read addresses use the state that holds once the item now executing commits.
    assign in_op    = s_tdata[15:12];
    assign base_sel = e_fire ? base_nx : base_reg;
    assign fn_sel   = e_fire ? fn_nx : fn_reg;
    assign ra_sum   = SW'(base_sel)
                    + SW'((in_op == OP_CALL) ? s_tdata[11:8] : s_tdata[7:4]);
    assign rb_sum   = SW'(base_sel) + SW'(s_tdata[3:0]);
    assign ra_addr  = ra_sum[BW-1:0];
    assign rb_addr  = rb_sum[BW-1:0];
    assign ra_ok    = ra_sum < SW'(REG_DEPTH);
    assign rb_ok    = rb_sum < SW'(REG_DEPTH);
    assign k_sum    = 32'(fn_sel) * 32'(CONSTS_PER_FUNC) + 32'(s_tdata[7:0]);
    assign k_addr   = k_sum[CAW-1:0];

    rwv_ram #(.WIDTH(VALUE_W), .DEPTH(REG_DEPTH)) u_regs_a (
        .aclk  (aclk),
        .we    (do_reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (in_fire),
        .raddr (ra_addr),
        .rdata (ram_a_q)
    );

    rwv_ram #(.WIDTH(VALUE_W), .DEPTH(REG_DEPTH)) u_regs_b (
        .aclk  (aclk),
        .we    (do_reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (in_fire),
        .raddr (rb_addr),
        .rdata (ram_b_q)
    );

    rwv_ram #(.WIDTH(VALUE_W), .DEPTH(CDEPTH)) u_consts (
        .aclk  (aclk),
        .we    (do_const_we),
        .waddr (const_waddr),
        .wdata (e_cval_reg),
        .re    (in_fire),
        .raddr (k_addr),
        .rdata (ram_k_q)
    );

    assign rd_p = qa_hit_reg ? qa_val_reg : (qa_vld_reg ? ram_a_q : '0);
    assign rd_q = qb_hit_reg ? qb_val_reg : (qb_vld_reg ? ram_b_q : '0);
    assign rd_k = k_hit_reg ? k_val_reg : ram_k_q;

    rwv_exec #(
        .REG_DEPTH       (REG_DEPTH),
        .NUM_FUNCS       (NUM_FUNCS),
        .CONSTS_PER_FUNC (CONSTS_PER_FUNC),
        .PROG_DEPTH      (PROG_DEPTH)
    ) u_exec (
        .action          (e_act_reg),
        .instr           (e_ins_reg),
        .const_function  (e_cfn_reg),
        .const_slot      (e_slot_reg),
        .halt            (halt_reg),
        .cur_fn          (fn_reg),
        .pc              (pc_reg),
        .base            (base_reg),
        .saved_fn        (sfn_reg),
        .saved_pc        (spc_reg),
        .saved_base      (sbase_reg),
        .rd_p            (rd_p),
        .rd_q            (rd_q),
        .rd_const        (rd_k),
        .halt_next       (halt_nx),
        .fn_next         (fn_nx),
        .pc_next         (pc_nx),
        .base_next       (base_nx),
        .saved_fn_next   (sfn_nx),
        .saved_pc_next   (spc_nx),
        .saved_base_next (sbase_nx),
        .reg_we          (reg_we),
        .reg_waddr       (reg_waddr),
        .reg_wdata       (reg_wdata),
        .const_we        (const_we),
        .const_waddr     (const_waddr),
        .result          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            halt_reg    <= 1'b0;
            fn_reg      <= '0;
            pc_reg      <= '0;
            base_reg    <= '0;
            sfn_reg     <= '0;
            spc_reg     <= '0;
            sbase_reg   <= '0;
            vld_reg     <= '0;
        end else begin
            if (in_fire) begin
                e_valid_reg <= 1'b1;
            end else if (e_fire) begin
                e_valid_reg <= 1'b0;
            end
            if (e_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (e_fire) begin
                halt_reg  <= halt_nx;
                fn_reg    <= fn_nx;
                pc_reg    <= pc_nx;
                base_reg  <= base_nx;
                sfn_reg   <= sfn_nx;
                spc_reg   <= spc_nx;
                sbase_reg <= sbase_nx;
            end
            if (do_reg_we) begin
                vld_reg[reg_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            e_act_reg  <= s_tuser;
            e_ins_reg  <= s_tdata[15:0];
            e_cfn_reg  <= s_tdata[17:16];
            e_slot_reg <= s_tdata[21:18];
            e_cval_reg <= s_tdata[53:22];
            qa_hit_reg <= do_reg_we && (reg_waddr == ra_addr);
            qb_hit_reg <= do_reg_we && (reg_waddr == rb_addr);
            k_hit_reg  <= do_const_we && (const_waddr == k_addr);
            qa_val_reg <= reg_wdata;
            qb_val_reg <= reg_wdata;
            k_val_reg  <= e_cval_reg;
            qa_vld_reg <= ra_ok && vld_reg[ra_addr];
            qb_vld_reg <= rb_ok && vld_reg[rb_addr];
        end
        if (e_fire) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), m_res_reg};

`ifndef SYNTHESIS
    a_ready_when_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled while the result register is free");

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    a_base_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        e_fire |=> (SW'(base_reg) < SW'(REG_DEPTH)))
        else $error("window base left the register store");

    a_write_not_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_res_reg.wrote && m_res_reg.fault))
        else $error("a faulted transaction reports a register write");
`endif

endmodule
